// ----- rtl/ptom_pkg.sv -----
package ptom_pkg;

    localparam int ENTRY_COUNT = 64;
    localparam int ENTRY_AW    = 6;
    localparam int SIDE_DEPTH_DEFAULT = 32;
    localparam int MAX_FILLS   = 32;

    // Entry word: side, order id, price, remaining, arrival (lowest bit up:
    // arrival, remaining, price, order id, side).
    localparam int ENTRY_W = 1 + 32 + 32 + 32 + 32;

    typedef struct packed {
        logic        side;
        logic [31:0] order_id;
        logic [31:0] price;
        logic [31:0] remaining;
        logic [31:0] arrival;
    } t_entry;

    localparam logic [2:0] ST_TRADE   = 3'd0;
    localparam logic [2:0] ST_FILLED  = 3'd1;
    localparam logic [2:0] ST_RESTED  = 3'd2;
    localparam logic [2:0] ST_MKT_REM = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

endpackage

// ----- rtl/ptom_ram.sv -----
module ptom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/price_time_order_matcher.sv -----
// Each best-price scan reads all 64 book entries, one a cycle; after a fill
// the book is rescanned, and the closing summary follows the final scan.
// Throughput: one order at a time; the next is taken after its summary transfer.
// Reset (i_rst_n low, synchronous): book empty (valid bits cleared), arrival
// counter zero, no result pending. Entry memory contents are left as is.
module price_time_order_matcher
    import ptom_pkg::*;
#(
    parameter int SIDE_DEPTH = SIDE_DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // order_id[31:0], side[32], order_kind[33], limit_price[65:34],
    // quantity[97:66], timestamp[145:98], zero fill to 152
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // taker_id[31:0], resting_id[63:32], trade_price[95:64], fill_qty[127:96],
    // trade_time[175:128], end_status[178:176], zero fill to 184
    output logic [183:0] m_axis_tdata,
    output logic         m_axis_tuser,  // result_kind
    output logic         m_axis_tlast
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_RMW   = 3'd5;

    localparam int CW = $clog2(ENTRY_COUNT + 1);

    logic [2:0]          r_state, n_state;
    logic [ENTRY_COUNT-1:0] r_valid;
    logic [31:0]         r_arr_cnt;

    // Order being worked
    logic [31:0]         r_id, r_limit, r_rem;
    logic                r_side, r_mkt;
    logic [47:0]         r_time;
    logic [5:0]          r_nfill;

    // Scan
    logic [ENTRY_AW:0]   r_addr;      // read address issued, with end bit
    logic                r_rd_vld;
    logic [ENTRY_AW-1:0] r_rd_idx;
    logic                r_best_vld;
    logic [ENTRY_AW-1:0] r_best_idx;
    t_entry              r_best;
    logic [CW-1:0]       r_count;
    logic                r_slot_vld;
    logic [ENTRY_AW-1:0] r_slot;

    // Output register
    logic                r_ov;
    logic [183:0]        r_odata;
    logic                r_okind;

    // Memory port
    logic                mem_we;
    logic [ENTRY_AW-1:0] mem_waddr;
    t_entry              mem_wdata, rd_entry;
    logic [ENTRY_W-1:0]  rd_word;

    ptom_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRY_COUNT)) u_book (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr[ENTRY_AW-1:0]),
        .o_rdata (rd_word)
    );
    assign rd_entry = t_entry'(rd_word);

    // Compare read entry with current best on the opposite side
    logic cand, better;
    logic [31:0] age_new, age_best;
    always_comb begin
        cand     = r_rd_vld && r_valid[r_rd_idx] && (rd_entry.side != r_side);
        age_new  = r_arr_cnt - rd_entry.arrival;
        age_best = r_arr_cnt - r_best.arrival;
        if (!r_best_vld) begin
            better = 1'b1;
        end else if (rd_entry.price != r_best.price) begin
            better = r_side ? (rd_entry.price > r_best.price)
                            : (rd_entry.price < r_best.price);
        end else begin
            better = age_new > age_best;
        end
    end

    logic        crosses;
    logic [31:0] fill;
    always_comb begin
        crosses = r_mkt || (r_side ? (r_best.price >= r_limit)
                                   : (r_best.price <= r_limit));
        fill    = (r_rem < r_best.remaining) ? r_rem : r_best.remaining;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_okind;

    logic scan_done;
    assign scan_done = r_addr[ENTRY_AW] && !r_rd_vld;

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_best_idx;
        mem_wdata = r_best;
        mem_wdata.remaining = r_best.remaining - fill;
        case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = S_SCAN;
            S_SCAN: if (scan_done) n_state = S_DEC;
            S_DEC: begin
                if (r_rem != '0 && r_nfill != 6'(MAX_FILLS) && r_best_vld && crosses) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_OUT: if (!r_ov) begin
                mem_we  = 1'b1;
                n_state = S_RMW;
            end
            S_RMW: n_state = S_SCAN;
            S_SUM: if (!r_ov) begin
                if (r_rem != '0 && !r_mkt && r_count < CW'(SIDE_DEPTH) && r_slot_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_slot;
                    mem_wdata = '{side: r_side, order_id: r_id, price: r_limit,
                                  remaining: r_rem, arrival: r_arr_cnt};
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_arr_cnt <= '0;
            r_ov      <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            r_rd_vld <= (r_state == S_SCAN) && !r_addr[ENTRY_AW];
            case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_id    <= s_axis_tdata[31:0];
                    r_side  <= s_axis_tdata[32];
                    r_mkt   <= s_axis_tdata[33];
                    r_limit <= s_axis_tdata[65:34];
                    r_rem   <= s_axis_tdata[97:66];
                    r_time  <= s_axis_tdata[145:98];
                    r_nfill <= '0;
                    r_addr  <= '0;
                    r_best_vld <= 1'b0;
                    r_count    <= '0;
                    r_slot_vld <= 1'b0;
                end
                S_SCAN: begin
                    if (!r_addr[ENTRY_AW]) begin
                        r_rd_idx <= r_addr[ENTRY_AW-1:0];
                        r_addr   <= r_addr + 1'b1;
                    end
                    if (r_rd_vld) begin
                        if (cand && better) begin
                            r_best_vld <= 1'b1;
                            r_best_idx <= r_rd_idx;
                            r_best     <= rd_entry;
                        end
                        if (r_valid[r_rd_idx]) begin
                            if (rd_entry.side == r_side) r_count <= r_count + 1'b1;
                        end else if (!r_slot_vld) begin
                            r_slot_vld <= 1'b1;
                            r_slot     <= r_rd_idx;
                        end
                    end
                end
                S_OUT: if (!r_ov) begin
                    r_ov    <= 1'b1;
                    r_okind <= 1'b0;
                    r_odata <= {5'd0, ST_TRADE, r_time, fill, r_best.price,
                                r_best.order_id, r_id};
                    r_rem   <= r_rem - fill;
                    r_nfill <= r_nfill + 1'b1;
                    if (r_best.remaining == fill) r_valid[r_best_idx] <= 1'b0;
                end
                S_RMW: begin
                    r_addr     <= '0;
                    r_best_vld <= 1'b0;
                    r_count    <= '0;
                    r_slot_vld <= 1'b0;
                end
                S_SUM: if (!r_ov) begin
                    r_ov    <= 1'b1;
                    r_okind <= 1'b1;
                    if (r_rem == '0) begin
                        r_odata <= {5'd0, ST_FILLED, r_time, r_rem, 64'd0, r_id};
                    end else if (r_mkt) begin
                        r_odata <= {5'd0, ST_MKT_REM, r_time, r_rem, 64'd0, r_id};
                    end else if (r_count < CW'(SIDE_DEPTH) && r_slot_vld) begin
                        r_odata <= {5'd0, ST_RESTED, r_time, r_rem, 64'd0, r_id};
                        r_valid[r_slot] <= 1'b1;
                        r_arr_cnt <= r_arr_cnt + 1'b1;
                    end else begin
                        r_odata <= {5'd0, ST_DROPPED, r_time, r_rem, 64'd0, r_id};
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // Held result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_odata))
        else $error("result changed while stalled");
    // Book write only from fill or summary states
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_OUT || r_state == S_SUM))
        else $error("unexpected book write");
    // Non-summary results always carry trade status
    a_trade_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_okind |-> r_odata[178:176] == ST_TRADE)
        else $error("trade with summary status");
`endif

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    import ptom_pkg::*;

    localparam logic SIDE_BUY     = 1'b0;
    localparam logic SIDE_SELL    = 1'b1;
    localparam logic KIND_LIMIT   = 1'b0;
    localparam logic KIND_MARKET  = 1'b1;
    localparam logic RES_TRADE    = 1'b0;
    localparam logic RES_SUMMARY  = 1'b1;
    localparam int   BOOK_SIDE_MAX = SIDE_DEPTH_DEFAULT;

    typedef struct packed {
        logic [47:0] ts;
        logic [31:0] qty;
        logic [31:0] price;
        logic        kind;
        logic        side;
        logic [31:0] id;
    } t_order;

    typedef struct {
        logic        res_kind;
        logic [31:0] taker;
        logic [31:0] maker;
        logic [31:0] price;
        logic [31:0] qty;
        logic [47:0] ts;
        logic [2:0]  status;
        logic        last;
    } t_fill;

    // Book predictor and expected-fill store
    class book_scoreboard;
        bit          live[ENTRY_COUNT];
        bit          bside[ENTRY_COUNT];
        logic [31:0] bid_id[ENTRY_COUNT];
        logic [31:0] bprice[ENTRY_COUNT];
        logic [31:0] bremain[ENTRY_COUNT];
        logic [31:0] barrive[ENTRY_COUNT];
        logic [31:0] arrive_cnt;
        t_fill       fills_due[$];
        int          errors;

        function new();
            foreach (live[i]) live[i] = 0;
            arrive_cnt = 0;
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction

        // Best price first, oldest (largest wrapped age) on ties
        function int best_maker(bit s);
            int b;
            b = -1;
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                if (!live[i] || bside[i] != s) continue;
                if (b < 0) begin
                    b = i;
                end else if (bprice[i] != bprice[b]) begin
                    if (s ? (bprice[i] < bprice[b]) : (bprice[i] > bprice[b])) b = i;
                end else if ((arrive_cnt - barrive[i]) > (arrive_cnt - barrive[b])) begin
                    b = i;
                end
            end
            return b;
        endfunction

        function void note_order(t_order o);
            logic [31:0] rem, fq;
            int          n, b, cnt, slot;
            t_fill       f;
            logic [2:0]  st;
            rem = o.qty;
            n = 0;
            while (rem != 0 && n < MAX_FILLS) begin
                b = best_maker(!o.side);
                if (b < 0) break;
                if (o.kind == KIND_LIMIT &&
                    !((o.side == SIDE_BUY) ? (bprice[b] <= o.price) : (bprice[b] >= o.price)))
                    break;
                fq = (rem < bremain[b]) ? rem : bremain[b];
                f = '{RES_TRADE, o.id, bid_id[b], bprice[b], fq, o.ts, ST_TRADE, 1'b0};
                fills_due.insert(fills_due.size(), f);
                n++;
                bremain[b] -= fq;
                if (bremain[b] == 0) live[b] = 0;
                rem -= fq;
            end
            if (rem == 0) begin
                st = ST_FILLED;
            end else if (o.kind == KIND_MARKET) begin
                st = ST_MKT_REM;
            end else begin
                cnt = 0;
                slot = -1;
                for (int i = 0; i < ENTRY_COUNT; i++) begin
                    if (live[i]) begin
                        if (bside[i] == o.side) cnt++;
                    end else if (slot < 0) begin
                        slot = i;
                    end
                end
                if (cnt >= BOOK_SIDE_MAX || slot < 0) begin
                    st = ST_DROPPED;
                end else begin
                    live[slot] = 1;
                    bside[slot] = o.side;
                    bid_id[slot] = o.id;
                    bprice[slot] = o.price;
                    bremain[slot] = rem;
                    barrive[slot] = arrive_cnt;
                    arrive_cnt++;
                    st = ST_RESTED;
                end
            end
            f = '{RES_SUMMARY, o.id, 32'd0, 32'd0, rem, o.ts, st, 1'b1};
            fills_due.insert(fills_due.size(), f);
        endfunction

        function void check_result(t_fill got);
            t_fill e;
            if (fills_due.size() == 0) begin
                report($sformatf("unexpected result taker %0h", got.taker));
                return;
            end
            e = fills_due.pop_front();
            if (got.res_kind !== e.res_kind)
                report($sformatf("kind %0b exp %0b", got.res_kind, e.res_kind));
            if (got.taker !== e.taker)
                report($sformatf("taker %0h exp %0h", got.taker, e.taker));
            if (got.maker !== e.maker)
                report($sformatf("maker %0h exp %0h", got.maker, e.maker));
            if (got.price !== e.price)
                report($sformatf("price %0h exp %0h", got.price, e.price));
            if (got.qty !== e.qty)
                report($sformatf("qty %0h exp %0h", got.qty, e.qty));
            if (got.ts !== e.ts)
                report($sformatf("time %0h exp %0h", got.ts, e.ts));
            if (got.status !== e.status)
                report($sformatf("status %0d exp %0d", got.status, e.status));
            if (got.last !== e.last)
                report($sformatf("last %0b exp %0b", got.last, e.last));
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;   // order_id, side, order_kind, limit_price, quantity, timestamp
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [183:0] m_axis_tdata;   // taker_id, resting_id, trade_price, fill_qty, trade_time, end_status
    logic         m_axis_tuser;   // result_kind
    logic         m_axis_tlast;

    book_scoreboard sb;
    bit idle_en;
    bit hold_req;
    bit hold_on;
    int next_id;

    price_time_order_matcher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Overall time limit
    initial begin
        #30000000;
        $display("price_time_order_matcher verification failed");
        $finish;
    end

    // Long output hold-off, counted here
    initial begin
        hold_on = 0;
        wait (hold_req);
        hold_on = 1;
        repeat (700) @(negedge i_clk);
        hold_on = 0;
    end

    // Result side: random stalls when idling is enabled, plus the long hold-off
    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = !hold_on && (!idle_en || $urandom_range(99) >= 14);
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        t_fill got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.res_kind = m_axis_tuser;
            got.taker    = m_axis_tdata[31:0];
            got.maker    = m_axis_tdata[63:32];
            got.price    = m_axis_tdata[95:64];
            got.qty      = m_axis_tdata[127:96];
            got.ts       = m_axis_tdata[175:128];
            got.status   = m_axis_tdata[178:176];
            got.last     = m_axis_tlast;
            sb.check_result(got);
        end
    end

    task automatic send_order(t_order o);
        @(negedge i_clk);
        while (idle_en && $urandom_range(99) < 14) begin
            s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata  = {6'd0, o};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_order(o);
    endtask

    task automatic send_fields(bit s, bit k, logic [31:0] p, logic [31:0] q);
        t_order o;
        next_id++;
        o.id    = (next_id[0]) ? $urandom : next_id;
        o.side  = s;
        o.kind  = k;
        o.price = p;
        o.qty   = q;
        o.ts    = {16'($urandom), $urandom};
        send_order(o);
    endtask

    // Stop offering, then wait for every expected result
    task automatic drain_book();
        @(negedge i_clk);
        s_axis_tvalid = 0;
        while (sb.fills_due.size() != 0) @(posedge i_clk);
    endtask

    // One random order; mode picks the traffic shape
    task automatic random_order(int mode, bit bias_side);
        bit          s, k;
        logic [31:0] p, q;
        int          r;
        r = $urandom_range(99);
        s = 1'($urandom_range(1));
        k = ($urandom_range(99) < 10) ? KIND_MARKET : KIND_LIMIT;
        p = $urandom_range(150, 350);
        q = $urandom_range(1, 60);
        if (mode == 1) begin
            // build up one side with limit orders
            s = bias_side;
            k = KIND_LIMIT;
            p = s ? $urandom_range(300, 399) : $urandom_range(100, 199);
            q = $urandom_range(1, 50);
            if (r < 12) begin
                // sweep the side just built
                s = !bias_side;
                k = KIND_MARKET;
                q = (r < 4) ? 32'hFFFF_FFFF : $urandom_range(20, 2000);
            end
        end else begin
            if (r < 5) p = $urandom;
            else if (r < 7) p = r[0] ? 32'hFFFF_FFFF : 32'd0;
            if (r >= 90 && r < 93) q = 0;
            else if (r >= 93 && r < 96) q = $urandom;
        end
        send_fields(s, k, p, q);
    endtask

    initial begin
        sb = new();
        idle_en = 0;
        hold_req = 0;
        next_id = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: empty book, zero quantity, time priority, price extremes
        send_fields(SIDE_BUY, KIND_LIMIT, 32'd50, 32'd0);
        send_fields(SIDE_BUY, KIND_MARKET, 32'd50, 32'd5);
        send_fields(SIDE_SELL, KIND_LIMIT, 32'd100, 32'd10);
        send_fields(SIDE_SELL, KIND_LIMIT, 32'd100, 32'd7);
        send_fields(SIDE_SELL, KIND_LIMIT, 32'd90, 32'd3);
        send_fields(SIDE_BUY, KIND_LIMIT, 32'd95, 32'd1);
        send_fields(SIDE_BUY, KIND_LIMIT, 32'd100, 32'd20);
        send_fields(SIDE_SELL, KIND_LIMIT, 32'd0, 32'hFFFF_FFFF);
        send_fields(SIDE_BUY, KIND_MARKET, 32'd0, 32'hFFFF_FFFF);
        send_fields(SIDE_BUY, KIND_LIMIT, 32'hFFFF_FFFF, 32'd5);
        send_fields(SIDE_SELL, KIND_LIMIT, 32'hFFFF_FFFF, 32'd2);
        send_fields(SIDE_SELL, KIND_MARKET, 32'hFFFF_FFFF, 32'd3);
        send_fields(SIDE_SELL, KIND_LIMIT, 32'h8000_0000, 32'h8000_0000);
        send_fields(SIDE_BUY, KIND_LIMIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_fields(SIDE_BUY, KIND_MARKET, 32'd1, 32'h8000_0000);

        // Random: first phase with no idling, then stalls, hold-off, pause
        for (int ph = 0; ph < 4; ph++) begin
            bit bs;
            int mode;
            bs = 1'($urandom_range(1));
            mode = (ph == 1 || ph == 3) ? 1 : 0;
            idle_en = (ph != 0);
            if (ph == 2) hold_req = 1;
            if (ph == 3) drain_book();
            for (int i = 0; i < 20; i++) random_order(mode, bs);
            // overfill the side, then clear it with a full sweep
            if (mode == 1) begin
                for (int i = 0; i < 34; i++)
                    send_fields(bs, KIND_LIMIT, bs ? 32'd350 : 32'd150, $urandom_range(1, 9));
                send_fields(!bs, KIND_MARKET, 32'd0, 32'hFFFF_FFFF);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid = 0;

        drain_book();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.fills_due.size() == 0) begin
            $display("price_time_order_matcher verification clean");
        end else begin
            $display("price_time_order_matcher verification failed");
        end
        $finish;
    end
endmodule
